@@ design/kli_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_pkg
// shared constants and types for the keyframe linear interpolator
// ----------------------------------------------------------------------------
package kli_pkg;
    localparam int KEY_DEPTH  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SLOT_W     = $clog2(KEY_DEPTH);
    localparam int CNT_W      = 6;
    localparam int TIME_W     = 32;
    localparam int VAL_W      = 32;
    localparam int FRAC_W     = 17;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;
endpackage

@@ design/keyframe_linear_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator
// keyed table of time and x/y/z values with a pipelined linear blend
// ----------------------------------------------------------------------------
// usage
//   input channel (i_valid / o_stall): one beat is a key write (cmd 0, slot,
//   time, x, y, z) or a sample (cmd 1, sample_time). writes give no result.
//   output channel (o_valid / i_stall): one beat per sample with x, y, z,
//   segment index, blend fraction and a not-found flag.
//   config channel (i_cfg_valid / o_cfg_ready): keys_in_use, to be written
//   only while idle (the block does not enforce it); ready is always high.
//   throughput: one beat per cycle while the receiver does not stall; the
//   restoring divider retires one quotient bit in each stage but its first,
//   after the segment search and operand fetch.
//   the key table is held in flip-flops so stage 1 can read the two keys of
//   its segment; a write lands at the first stage so later samples see it,
//   samples already in flight that cross that write see the old key only if
//   they fetched it before (fetch happens in stage 1).
//   reset clears all valid bits and sets keys_in_use to 1; table contents are
//   undefined until written.
//   a stall from the receiver freezes the whole pipe; nothing is lost.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [4:0]  i_key_slot,
    input  logic [31:0] i_key_time,
    input  logic signed [31:0] i_key_x,
    input  logic signed [31:0] i_key_y,
    input  logic signed [31:0] i_key_z,
    input  logic [31:0] i_sample_time,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic [4:0]  o_segment_index,
    output logic [16:0] o_blend_fraction,
    output logic        o_not_found
);
    localparam int NS  = kli_pkg::QUO_W;      // divider stages
    localparam int NW  = kli_pkg::TIME_W + 1; // magnitude width
    localparam int DEP = kli_pkg::KEY_DEPTH;
    localparam int SW  = kli_pkg::SLOT_W;

    logic adv;
    assign adv = !i_stall;
    assign o_stall = i_stall;
    assign o_cfg_ready = 1'b1;

    logic [kli_pkg::CNT_W-1:0] r_keys;
    logic [31:0] r_t [DEP];
    logic [31:0] r_x [DEP];
    logic [31:0] r_y [DEP];
    logic [31:0] r_z [DEP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= kli_pkg::CNT_W'(1);
        end else if (i_cfg_valid) begin
            r_keys <= i_cfg_data;
        end
    end

    // key writes go straight into the table
    always_ff @(posedge i_clk) begin
        if (i_valid && adv && i_cmd == kli_pkg::CMD_WRITE) begin
            r_t[i_key_slot[SW-1:0]] <= i_key_time;
            r_x[i_key_slot[SW-1:0]] <= i_key_x;
            r_y[i_key_slot[SW-1:0]] <= i_key_y;
            r_z[i_key_slot[SW-1:0]] <= i_key_z;
        end
    end

    // stage 0: clamp key count, compare against every key time in use but the first
    logic [5:0] n_cnt;
    logic [DEP-1:0] n_hit;
    always_comb begin
        n_cnt = r_keys;
        if (n_cnt == 6'd0) n_cnt = 6'd1;
        if (n_cnt > 6'(DEP)) n_cnt = 6'(DEP);
        for (int k = 0; k < DEP; k++) begin
            n_hit[k] = (k >= 1) && (k < int'(n_cnt)) && (i_sample_time < r_t[k]);
        end
    end

    logic r_s0_v, r_s0_single;
    logic [DEP-1:0] r_s0_hit;
    logic [31:0] r_s0_t;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s0_v <= 1'b0;
        else if (adv) r_s0_v <= i_valid && i_cmd == kli_pkg::CMD_SAMPLE;
        if (adv) begin
            r_s0_hit    <= n_hit;
            r_s0_single <= (n_cnt == 6'd1);
            r_s0_t      <= i_sample_time;
        end
    end

    // stage 1: priority pick of the first hit, fetch the segment keys
    logic [SW-1:0] n_seg;
    logic n_miss;
    always_comb begin
        n_seg = '0;
        n_miss = 1'b1;
        for (int k = DEP-1; k >= 1; k--) begin
            if (r_s0_hit[k]) begin
                n_seg = SW'(k - 1);
                n_miss = 1'b0;
            end
        end
    end

    logic r_s1_v, r_s1_single, r_s1_miss;
    logic [SW-1:0] r_s1_seg;
    logic [31:0] r_s1_t, r_s1_ta, r_s1_tb;
    logic signed [31:0] r_s1_xa, r_s1_xb, r_s1_ya, r_s1_yb, r_s1_za, r_s1_zb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_v <= 1'b0;
        else if (adv) r_s1_v <= r_s0_v;
        if (adv) begin
            r_s1_single <= r_s0_single;
            r_s1_miss   <= n_miss;
            r_s1_seg    <= n_seg;
            r_s1_t      <= r_s0_t;
            r_s1_ta <= r_t[n_seg];
            r_s1_tb <= r_t[n_seg + SW'(1)];
            r_s1_xa <= r_x[n_seg]; r_s1_xb <= r_x[n_seg + SW'(1)];
            r_s1_ya <= r_y[n_seg]; r_s1_yb <= r_y[n_seg + SW'(1)];
            r_s1_za <= r_z[n_seg]; r_s1_zb <= r_z[n_seg + SW'(1)];
        end
    end

    // stage 2: signed length and numerator, sign fold, clamp decisions
    logic signed [NW:0] n_len, n_num;
    logic n_zero, n_one;
    always_comb begin
        n_len = $signed({2'b00, r_s1_tb}) - $signed({2'b00, r_s1_ta});
        n_num = $signed({2'b00, r_s1_t}) - $signed({2'b00, r_s1_ta});
        if (n_len < 0) begin
            n_len = -n_len;
            n_num = -n_num;
        end
        n_zero = (n_len == 0) || (n_num <= 0) || r_s1_single;
        n_one  = !n_zero && (n_num >= n_len);
    end

    // divider pipeline, one quotient bit per stage after the first
    logic          r_d_v    [NS+1];
    logic          r_d_zero [NS+1];
    logic          r_d_one  [NS+1];
    logic          r_d_miss [NS+1];
    logic          r_d_sgl  [NS+1];
    logic [SW-1:0] r_d_seg  [NS+1];
    logic [NW-1:0] r_d_rem  [NS+1];
    logic [NW-1:0] r_d_den  [NS+1];
    logic [NS-1:0] r_d_q    [NS+1];
    logic [31:0]   r_d_xa [NS+1], r_d_xb [NS+1], r_d_ya [NS+1], r_d_yb [NS+1];
    logic [31:0]   r_d_za [NS+1], r_d_zb [NS+1];

    // num < len here, so remainder stays below len and each bit is a shift-compare
    logic [NW:0] n_sh [NS];
    logic [NW:0] n_df [NS];
    always_comb begin
        for (int s = 0; s < NS; s++) begin
            n_sh[s] = {r_d_rem[s], 1'b0};
            n_df[s] = n_sh[s] - {1'b0, r_d_den[s]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NS; s++) begin
                r_d_v[s] <= 1'b0;
            end
        end else if (adv) begin
            r_d_v[0] <= r_s1_v;
            for (int s = 0; s < NS; s++) begin
                r_d_v[s+1] <= r_d_v[s];
            end
        end
        if (adv) begin
            r_d_zero[0] <= n_zero;
            r_d_one[0]  <= n_one;
            r_d_miss[0] <= r_s1_miss && !r_s1_single;
            r_d_sgl[0]  <= r_s1_single;
            r_d_seg[0]  <= r_s1_single ? '0 : r_s1_seg;
            r_d_rem[0]  <= n_num[NW-1:0];
            r_d_den[0]  <= n_len[NW-1:0];
            r_d_q[0]    <= '0;
            r_d_xa[0] <= r_s1_xa; r_d_xb[0] <= r_s1_xb;
            r_d_ya[0] <= r_s1_ya; r_d_yb[0] <= r_s1_yb;
            r_d_za[0] <= r_s1_za; r_d_zb[0] <= r_s1_zb;
            for (int s = 0; s < NS; s++) begin
                r_d_zero[s+1] <= r_d_zero[s];
                r_d_one[s+1]  <= r_d_one[s];
                r_d_miss[s+1] <= r_d_miss[s];
                r_d_sgl[s+1]  <= r_d_sgl[s];
                r_d_seg[s+1]  <= r_d_seg[s];
                r_d_den[s+1]  <= r_d_den[s];
                if (s == 0) begin
                    r_d_rem[s+1] <= r_d_rem[s];
                    r_d_q[s+1]   <= r_d_q[s];
                end else if (!n_df[s][NW]) begin
                    r_d_rem[s+1] <= n_df[s][NW-1:0];
                    r_d_q[s+1]   <= {r_d_q[s][NS-2:0], 1'b1};
                end else begin
                    r_d_rem[s+1] <= n_sh[s][NW-1:0];
                    r_d_q[s+1]   <= {r_d_q[s][NS-2:0], 1'b0};
                end
                r_d_xa[s+1] <= r_d_xa[s]; r_d_xb[s+1] <= r_d_xb[s];
                r_d_ya[s+1] <= r_d_ya[s]; r_d_yb[s+1] <= r_d_yb[s];
                r_d_za[s+1] <= r_d_za[s]; r_d_zb[s+1] <= r_d_zb[s];
            end
        end
    end

    // fraction select and deltas
    logic [kli_pkg::FRAC_W-1:0] n_frac;
    always_comb begin
        if (r_d_zero[NS])     n_frac = '0;
        else if (r_d_one[NS]) n_frac = kli_pkg::FRAC_W'(1 << kli_pkg::FRAC_BITS);
        else                  n_frac = kli_pkg::FRAC_W'(r_d_q[NS]);
    end

    logic r_m_v, r_m_miss;
    logic [SW-1:0] r_m_seg;
    logic [kli_pkg::FRAC_W-1:0] r_m_frac;
    logic signed [32:0] r_m_dx, r_m_dy, r_m_dz;
    logic signed [31:0] r_m_ax, r_m_ay, r_m_az;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_v <= 1'b0;
        else if (adv) r_m_v <= r_d_v[NS];
        if (adv) begin
            r_m_miss <= r_d_miss[NS];
            r_m_seg  <= r_d_seg[NS];
            r_m_frac <= r_d_sgl[NS] ? '0 : n_frac;
            r_m_ax <= r_d_xa[NS]; r_m_ay <= r_d_ya[NS]; r_m_az <= r_d_za[NS];
            r_m_dx <= r_d_sgl[NS] ? '0 : $signed({r_d_xb[NS][31], r_d_xb[NS]})
                                       - $signed({r_d_xa[NS][31], r_d_xa[NS]});
            r_m_dy <= r_d_sgl[NS] ? '0 : $signed({r_d_yb[NS][31], r_d_yb[NS]})
                                       - $signed({r_d_ya[NS][31], r_d_ya[NS]});
            r_m_dz <= r_d_sgl[NS] ? '0 : $signed({r_d_zb[NS][31], r_d_zb[NS]})
                                       - $signed({r_d_za[NS][31], r_d_za[NS]});
        end
    end

    // multiply stage
    localparam int PW = 33 + kli_pkg::FRAC_W + 1;
    logic signed [PW-1:0] n_px, n_py, n_pz, r_px, r_py, r_pz;
    logic signed [kli_pkg::FRAC_W:0] n_fs;
    assign n_fs = $signed({1'b0, r_m_frac});
    assign n_px = PW'(r_m_dx * n_fs);
    assign n_py = PW'(r_m_dy * n_fs);
    assign n_pz = PW'(r_m_dz * n_fs);

    logic r_p_v, r_p_miss;
    logic [SW-1:0] r_p_seg;
    logic [kli_pkg::FRAC_W-1:0] r_p_frac;
    logic signed [31:0] r_p_ax, r_p_ay, r_p_az;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p_v <= 1'b0;
        else if (adv) r_p_v <= r_m_v;
        if (adv) begin
            r_p_miss <= r_m_miss; r_p_seg <= r_m_seg; r_p_frac <= r_m_frac;
            r_p_ax <= r_m_ax; r_p_ay <= r_m_ay; r_p_az <= r_m_az;
            r_px <= n_px; r_py <= n_py; r_pz <= n_pz;
        end
    end

    // round half up, add start, saturate
    function automatic logic [31:0] fin(input logic signed [31:0] a,
                                        input logic signed [PW-1:0] p);
        logic signed [PW-1:0] q;
        logic signed [PW:0] r;
        begin
            q = (p + PW'(1 << (kli_pkg::FRAC_BITS - 1))) >>> kli_pkg::FRAC_BITS;
            r = $signed({{(PW-31){a[31]}}, a}) + $signed({q[PW-1], q});
            if (r > $signed((PW+1)'(32'h7fffffff)))       fin = 32'h7fffffff;
            else if (r < -$signed((PW+1)'(33'h080000000))) fin = 32'h80000000;
            else                                           fin = r[31:0];
        end
    endfunction

    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= r_p_v;
        if (adv) begin
            o_out_x <= fin(r_p_ax, r_px);
            o_out_y <= fin(r_p_ay, r_py);
            o_out_z <= fin(r_p_az, r_pz);
            o_segment_index  <= 5'(r_p_seg);
            o_blend_fraction <= r_p_frac;
            o_not_found      <= r_p_miss;
        end
    end
    assign o_valid = r_ov;
endmodule

@@ design/kli_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_checker
// port-level checks for the keyframe linear interpolator
// ----------------------------------------------------------------------------
module kli_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_stall,
    input logic [16:0] o_blend_fraction,
    input logic        o_not_found,
    input logic [4:0]  o_segment_index
);
    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_blend_fraction))
        else $error("stalled result changed");
    // fraction never above one
    a_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_blend_fraction <= 17'h10000)
        else $error("fraction above one");
    // a miss uses segment zero
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_not_found |-> o_segment_index == 5'd0)
        else $error("miss not on segment zero");
    // back pressure passes straight upstream
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stall |-> o_stall)
        else $error("stall not propagated");
endmodule

bind keyframe_linear_interpolator kli_checker u_kli_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_stall(o_stall), .o_blend_fraction(o_blend_fraction),
    .o_not_found(o_not_found), .o_segment_index(o_segment_index)
);

@@ dv/kli_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_scoreboard
// watches the key, sample, config and result channels of the interpolator,
// predicts every sample result in order and compares it field by field
// ----------------------------------------------------------------------------
module kli_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic        i_cmd,
    input  logic [4:0]  i_key_slot,
    input  logic [31:0] i_key_time,
    input  logic [31:0] i_key_x,
    input  logic [31:0] i_key_y,
    input  logic [31:0] i_key_z,
    input  logic [31:0] i_sample_time,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_out_x,
    input  logic [31:0] i_out_y,
    input  logic [31:0] i_out_z,
    input  logic [4:0]  i_segment_index,
    input  logic [16:0] i_blend_fraction,
    input  logic        i_not_found,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [4:0]  seg;
        logic [16:0] frac;
        logic        miss;
    } t_blend;

    logic [31:0] key_t [kli_pkg::KEY_DEPTH];
    logic signed [31:0] key_x [kli_pkg::KEY_DEPTH];
    logic signed [31:0] key_y [kli_pkg::KEY_DEPTH];
    logic signed [31:0] key_z [kli_pkg::KEY_DEPTH];
    logic [5:0]  key_count;
    t_blend      blend_q [$];
    int          err_count = 0;

    function automatic logic [31:0] mix(logic signed [31:0] a, logic signed [31:0] b,
                                        longint f);
        longint d, p, r;
        d = longint'(b) - longint'(a);
        p = d * f + (longint'(1) << (kli_pkg::FRAC_BITS - 1));
        r = longint'(a) + (p >>> kli_pkg::FRAC_BITS);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic t_blend sample_at(logic [31:0] t);
        t_blend res;
        int n, seg, nx;
        longint num, len, f;
        logic miss;
        n = key_count;
        if (n < 1) n = 1;
        if (n > kli_pkg::KEY_DEPTH) n = kli_pkg::KEY_DEPTH;
        if (n == 1) begin
            res = '0;
            res.x = key_x[0];
            res.y = key_y[0];
            res.z = key_z[0];
            return res;
        end
        seg = 0;
        miss = 1'b1;
        for (int k = 0; k + 1 < n; k++) begin
            if (miss && t < key_t[k+1]) begin
                seg = k;
                miss = 1'b0;
            end
        end
        nx = seg + 1;
        len = longint'(key_t[nx]) - longint'(key_t[seg]);
        num = longint'(t) - longint'(key_t[seg]);
        if (len < 0) begin
            len = -len;
            num = -num;
        end
        if (len == 0 || num <= 0) f = 0;
        else if (num >= len) f = longint'(1) << kli_pkg::FRAC_BITS;
        else f = (num << kli_pkg::FRAC_BITS) / len;
        res.x = mix(key_x[seg], key_x[nx], f);
        res.y = mix(key_y[seg], key_y[nx], f);
        res.z = mix(key_z[seg], key_z[nx], f);
        res.seg = seg[4:0];
        res.frac = f[16:0];
        res.miss = miss;
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            err_count++;
        end
    endtask

    assign o_errors = err_count;
    assign o_pending = blend_q.size();

    always @(posedge i_clk) begin
        t_blend want;
        if (!i_rst_n) begin
            key_count <= 6'd1;
        end else begin
            if (i_cfg_valid && i_cfg_ready) key_count <= i_cfg_data;
            if (i_valid && !i_in_stall) begin
                if (i_cmd == kli_pkg::CMD_WRITE) begin
                    key_t[i_key_slot] <= i_key_time;
                    key_x[i_key_slot] <= i_key_x;
                    key_y[i_key_slot] <= i_key_y;
                    key_z[i_key_slot] <= i_key_z;
                end else begin
                    blend_q.insert(blend_q.size(), sample_at(i_sample_time));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (blend_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    err_count++;
                end else begin
                    want = blend_q.pop_front();
                    check_field("out_x", want.x, i_out_x);
                    check_field("out_y", want.y, i_out_y);
                    check_field("out_z", want.z, i_out_z);
                    check_field("segment_index", 32'(want.seg), 32'(i_segment_index));
                    check_field("blend_fraction", 32'(want.frac), 32'(i_blend_fraction));
                    check_field("not_found", 32'(want.miss), 32'(i_not_found));
                end
            end
        end
    end
endmodule

@@ dv/tb_keyframe_linear_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_linear_interpolator
// loads key tables while idle, sets the key count from 0 up to 63 and
// fires samples at key boundaries, gaps and extremes under random idling;
// the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_keyframe_linear_interpolator;
    localparam int DRAIN = 30;      // a bit above the pipe latency
    localparam int STUCK = 20000;   // cycles without any beat before giving up

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_cmd;
    logic [4:0]  i_key_slot;
    logic [31:0] i_key_time;
    logic signed [31:0] i_key_x, i_key_y, i_key_z;
    logic [31:0] i_sample_time;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic [4:0]  o_segment_index;
    logic [16:0] o_blend_fraction;
    logic        o_not_found;

    int errors, pending;
    int send_idle_pct, recv_stall_pct;
    int quiet = 0;
    int items;
    logic [31:0] table_t [kli_pkg::KEY_DEPTH];   // stimulus copy of key times for aiming
    int eff_keys;

    keyframe_linear_interpolator DUT (.*);

    kli_scoreboard u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_stall(o_stall), .i_cmd(i_cmd),
        .i_key_slot(i_key_slot), .i_key_time(i_key_time),
        .i_key_x(i_key_x), .i_key_y(i_key_y), .i_key_z(i_key_z),
        .i_sample_time(i_sample_time),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_x(o_out_x), .i_out_y(o_out_y), .i_out_z(o_out_z),
        .i_segment_index(o_segment_index), .i_blend_fraction(o_blend_fraction),
        .i_not_found(o_not_found),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stalls at random, rate set per phase
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog: any beat on any channel keeps it quiet
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STUCK) begin
            $display("tb_keyframe_linear_interpolator: errors");
            $finish;
        end
    end

    // one input beat; valid stays high into the next beat when no gap is drawn
    task automatic send_beat(logic cmd, logic [4:0] slot, logic [31:0] kt,
                             logic [31:0] kx, logic [31:0] ky, logic [31:0] kz,
                             logic [31:0] st);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_key_slot <= slot;
        i_key_time <= kt;
        i_key_x <= kx;
        i_key_y <= ky;
        i_key_z <= kz;
        i_sample_time <= st;
        taken = 0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end
        if (cmd == kli_pkg::CMD_WRITE) table_t[slot] = kt;
        items++;
    endtask

    task automatic sample(logic [31:0] st);
        send_beat(kli_pkg::CMD_SAMPLE, 5'($urandom), $urandom, $urandom, $urandom,
                  $urandom, st);
    endtask

    // bring the pipe to rest, then give it the drain time
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_keys(logic [5:0] n);
        bit taken;
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= n;
        taken = 0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        eff_keys = (n == 0) ? 1 : (n > kli_pkg::KEY_DEPTH ? kli_pkg::KEY_DEPTH : n);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(65535)) - 32'd32768;
            default: return $urandom;
        endcase
    endfunction

    // sample time aimed at the loaded key times most of the time
    function automatic logic [31:0] pick_time();
        logic [31:0] kt;
        kt = table_t[$urandom_range(eff_keys - 1)];
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return $urandom;
            3: return kt;
            4: return kt - 1;
            5: return kt + 1;
            default: return kt + $urandom_range(32'h0003_0000);
        endcase
    endfunction

    initial begin
        logic [31:0] base, step;
        int n, slot;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = kli_pkg::CMD_WRITE;
        i_key_slot = '0;
        i_key_time = '0;
        i_key_x = '0;
        i_key_y = '0;
        i_key_z = '0;
        i_sample_time = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        items = 0;
        eff_keys = 1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: a full table with a zero-length and a decreasing segment
        for (int k = 0; k < kli_pkg::KEY_DEPTH; k++) begin
            base = (k == 5) ? 32'h0004_0000 : (k == 7) ? 32'h0005_0000 : 32'(k) << 16;
            send_beat(kli_pkg::CMD_WRITE, k[4:0], base,
                      (k % 3 == 0) ? 32'h8000_0000 : 32'(k) << 16,
                      (k % 2 == 0) ? 32'h7fff_ffff : 32'h8000_0000,
                      -(32'(k) << 12), 32'h0);
        end
        sample(32'h0001_8000);              // one key in use
        set_keys(6'd0);                     // zero acts as one
        sample(32'hffff_ffff);
        set_keys(6'd2);
        sample(32'h0);
        sample(32'h0000_4000);
        sample(32'hffff_ffff);              // past the end
        set_keys(6'd32);
        sample(32'h0004_0000);              // at the time of the zero-length segment
        sample(32'h0005_8000);              // between the times of the decreasing segment's keys
        sample(32'h001f_0000);
        sample(32'h0010_0001);
        set_keys(6'd63);                    // above depth acts as depth
        sample(32'h0);
        sample(32'hffff_ffff);

        // random: tables loaded at rest, then bursts of samples with stray writes
        while (items < 1000) begin
            if (items < 420) begin
                send_idle_pct = 7;
                recv_stall_pct = 80;
            end else if (items < 740) begin
                send_idle_pct = 80;
                recv_stall_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            settle();
            case ($urandom_range(9))
                0: n = 1;
                1: n = 2;
                2: n = 32;
                3: n = $urandom_range(33, 63);
                default: n = $urandom_range(2, 12);
            endcase
            eff_keys = (n > kli_pkg::KEY_DEPTH) ? kli_pkg::KEY_DEPTH : n;
            base = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0010_0000);
            for (int k = 0; k < eff_keys; k++) begin
                step = ($urandom_range(9) == 0) ? 32'h0
                     : ($urandom_range(9) == 0) ? -$urandom_range(32'h0002_0000)
                     : $urandom_range(1, 32'h0004_0000);
                base = base + step;
                send_beat(kli_pkg::CMD_WRITE, k[4:0], base, rand_val(), rand_val(),
                          rand_val(), $urandom);
            end
            set_keys(n[5:0]);
            repeat ($urandom_range(10, 30)) begin
                // stray writes only touch slots that the search cannot reach
                if (eff_keys < kli_pkg::KEY_DEPTH && $urandom_range(7) == 0) begin
                    slot = $urandom_range(eff_keys, kli_pkg::KEY_DEPTH - 1);
                    send_beat(kli_pkg::CMD_WRITE, slot[4:0], $urandom, $urandom,
                              $urandom, $urandom, $urandom);
                end else begin
                    sample(pick_time());
                end
            end
        end

        settle();
        if (errors == 0) begin
            $display("tb_keyframe_linear_interpolator: clean");
        end else begin
            $display("tb_keyframe_linear_interpolator: errors");
        end
        $finish;
    end
endmodule
